### hw/rtl/nplw_pkg.sv
// ---------------------------------------------------------------------------
// nplw_pkg
// Shared types, codes and helpers of the PRP list walker.
// ---------------------------------------------------------------------------
package nplw_pkg;

  localparam int NPLW_MAX_LIST_ENTRIES = 512;
  localparam int NPLW_QUEUE_DEPTH      = 4;

  // input item kinds
  localparam logic KIND_CMD   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  // result kinds
  localparam logic [1:0] RK_SEG   = 2'd0;
  localparam logic [1:0] RK_FETCH = 2'd1;
  localparam logic [1:0] RK_DONE  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_PAGE_SHIFT   = 3'd0;
  localparam logic [2:0] REG_LIST_ENTRIES = 3'd1;
  localparam logic [2:0] REG_CMB_ENABLE   = 3'd2;
  localparam logic [2:0] REG_CMB_BASE     = 3'd3;
  localparam logic [2:0] REG_CMB_BYTES    = 3'd4;

  typedef struct packed {
    logic [4:0]  sh;        // effective page shift, 12..16
    logic        cmb_en;
    logic [63:0] cmb_base;
    logic [31:0] cmb_bytes;
  } cfg_t;

  // one classified item: up to three results, the third is always done
  typedef struct packed {
    logic [1:0]  n;
    logic [1:0]  k0;
    logic [1:0]  k1;
    logic        st;
    logic        cmb;
    logic [63:0] addr0;
    logic [63:0] addr1;
    logic [31:0] amt0;      // byte count, or remaining bytes for a fetch
    logic [31:0] amt1;
  } job_t;

  function automatic logic [16:0] pg_bytes(input logic [4:0] sh);
    pg_bytes = 17'd1 << sh;
  endfunction

  function automatic logic [16:0] pg_offset_mask(input logic [4:0] sh);
    pg_offset_mask = pg_bytes(sh) - 17'd1;
  endfunction

endpackage

### hw/rtl/nplw_front.sv
// ---------------------------------------------------------------------------
// nplw_front
// Accepts commands and list entries, tracks the walk and classifies each
// command, and each entry during a walk, into a job for the result sequencer.
// ---------------------------------------------------------------------------
module nplw_front
  import nplw_pkg::*;
#(
  parameter int MAX_LIST_ENTRIES = NPLW_MAX_LIST_ENTRIES,
  localparam int IW = $clog2(MAX_LIST_ENTRIES),
  localparam int EW = $clog2(MAX_LIST_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic [EW-1:0] ents,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_kind,
  input  logic [63:0]   p1,
  input  logic [63:0]   p2,
  input  logic [31:0]   len,
  input  logic [63:0]   ent,
  input  logic          q_full,
  output logic          push,
  output job_t          job
);

  logic          walking, walking_next;
  logic [31:0]   bytes_left, bytes_left_next;
  logic [IW-1:0] entry_index, entry_index_next;
  logic          uses_cmb, uses_cmb_next;

  logic [16:0] ps, pmask, off, first;
  logic [31:0] first32, rem;
  logic [17:0] first_plus_ps;
  logic        le_first, rem_gt_ps, p2_mis, p1_in_cmb;
  logic [64:0] cdiff;
  logic        ent_bad, at_end, left_gt_ps;
  logic [31:0] seg, left_n;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_kind == KIND_CMD || walking);

  always_comb begin
    ps            = pg_bytes(cfg.sh);
    pmask         = pg_offset_mask(cfg.sh);
    off           = p1[16:0] & pmask;
    first         = ps - off;
    first32       = {15'b0, first};
    first_plus_ps = {1'b0, first} + {1'b0, ps};
    le_first      = len <= first32;
    rem_gt_ps     = len > {14'b0, first_plus_ps};
    rem           = len - first32;
    p2_mis        = (p2[16:0] & pmask) != 17'd0;
    // buffer membership, difference taken without wrap
    cdiff         = {1'b0, p1} - {1'b0, cfg.cmb_base};
    p1_in_cmb     = cfg.cmb_en && !cdiff[64] && cdiff[63:32] == 32'd0 &&
                    cdiff[31:0] < cfg.cmb_bytes;
    ent_bad       = ent == 64'd0 || (ent[16:0] & pmask) != 17'd0;
    at_end        = EW'(entry_index) >= ents - EW'(1);
    left_gt_ps    = bytes_left > {15'b0, ps};
    seg           = left_gt_ps ? {15'b0, ps} : bytes_left;
    left_n        = bytes_left - seg;
  end

  always_comb begin
    job              = '0;
    job.k0           = RK_DONE;
    job.k1           = RK_DONE;
    job.n            = 2'd1;
    walking_next     = walking;
    bytes_left_next  = bytes_left;
    entry_index_next = entry_index;
    uses_cmb_next    = uses_cmb;
    if (in_kind == KIND_CMD) begin
      walking_next     = 1'b0;
      bytes_left_next  = 32'd0;
      entry_index_next = '0;
      uses_cmb_next    = 1'b0;
      if (p1 == 64'd0) begin
        job.st = 1'b1;
      end else begin
        uses_cmb_next = p1_in_cmb;
        job.k0        = RK_SEG;
        job.addr0     = p1;
        job.amt0      = le_first ? len : first32;
        job.cmb       = p1_in_cmb;
        job.n         = 2'd2;
        job.addr1     = p2;
        job.amt1      = rem;
        if (le_first) begin
          job.st = 1'b0;
        end else if (p2 == 64'd0) begin
          job.st = 1'b1;
        end else if (rem_gt_ps) begin
          job.k1          = RK_FETCH;
          walking_next    = 1'b1;
          bytes_left_next = rem;
        end else if (p2_mis) begin
          job.st = 1'b1;
        end else begin
          job.k1 = RK_SEG;
          job.n  = 2'd3;
        end
      end
    end else begin
      job.addr0 = ent;
      if (ent_bad) begin
        job.st           = 1'b1;
        walking_next     = 1'b0;
        bytes_left_next  = 32'd0;
        entry_index_next = '0;
      end else if (at_end && left_gt_ps) begin
        // last slot chains to the next list page
        job.k0           = RK_FETCH;
        job.amt0         = bytes_left;
        entry_index_next = '0;
      end else begin
        job.k0           = RK_SEG;
        job.amt0         = seg;
        job.cmb          = uses_cmb;
        bytes_left_next  = left_n;
        entry_index_next = entry_index + IW'(1);
        if (!left_gt_ps) begin
          job.n            = 2'd2;
          walking_next     = 1'b0;
          entry_index_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking     <= 1'b0;
      bytes_left  <= 32'd0;
      entry_index <= '0;
      uses_cmb    <= 1'b0;
    end else if (push) begin
      walking     <= walking_next;
      bytes_left  <= bytes_left_next;
      entry_index <= entry_index_next;
      uses_cmb    <= uses_cmb_next;
    end
  end

endmodule

### hw/rtl/nplw_queue.sv
// ---------------------------------------------------------------------------
// nplw_queue
// Short job queue between the classifier and the result sequencer.
// ---------------------------------------------------------------------------
module nplw_queue
  import nplw_pkg::*;
#(
  parameter int DEPTH = NPLW_QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == CW'(0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("job popped from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !rst |=> count == CW'($past(count) + CW'($past(push)) - CW'($past(pop))))
    else $error("queue fill count out of step");

endmodule

### hw/rtl/nplw_back.sv
// ---------------------------------------------------------------------------
// nplw_back
// Result sequencer: expands each job into its results, one a cycle while the
// receiver accepts, into the output register.
// ---------------------------------------------------------------------------
module nplw_back
  import nplw_pkg::*;
#(
  parameter int MAX_LIST_ENTRIES = NPLW_MAX_LIST_ENTRIES,
  localparam int EW = $clog2(MAX_LIST_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic [EW-1:0] ents,
  input  job_t          head,
  input  logic          q_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [63:0]   out_addr,
  output logic [16:0]   out_amt,
  output logic          out_cmb,
  output logic          out_status,
  output logic          out_last
);

  logic [1:0]  idx;
  logic        load, fire, is_last;
  logic [1:0]  k;
  logic [63:0] a, seg_addr;
  logic [31:0] m;
  logic [32:0] nsum, nents;
  logic [16:0] fcnt;

  assign load    = !out_valid || out_ready;
  assign fire    = load && !q_empty;
  assign is_last = idx == head.n - 2'd1;
  assign pop     = fire && is_last;

  always_comb begin
    case (idx)
      2'd0: begin
        k = head.k0;
        a = head.addr0;
        m = head.amt0;
      end
      2'd1: begin
        k = head.k1;
        a = head.addr1;
        m = head.amt1;
      end
      default: begin
        k = RK_DONE;
        a = 64'd0;
        m = 32'd0;
      end
    endcase
    seg_addr = head.cmb ? a - cfg.cmb_base : a;
    // entries needed for the bytes left, capped at one list page
    nsum     = {1'b0, m} + {16'b0, pg_offset_mask(cfg.sh)};
    nents    = nsum >> cfg.sh;
    fcnt     = (nents < 33'(ents)) ? nents[16:0] : 17'(ents);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind   <= k;
      out_last   <= is_last;
      out_cmb    <= (k == RK_SEG) && head.cmb;
      out_status <= (k == RK_DONE) && head.st;
      case (k)
        RK_SEG: begin
          out_addr <= seg_addr;
          out_amt  <= m[16:0];
        end
        RK_FETCH: begin
          out_addr <= a;
          out_amt  <= fcnt;
        end
        default: begin
          out_addr <= 64'd0;
          out_amt  <= 17'd0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/nvme_prp_list_walker_unit.sv
// ---------------------------------------------------------------------------
// nvme_prp_list_walker_unit
// Walks NVMe PRP pointers and lists into page segments and list fetches.
// ---------------------------------------------------------------------------
// The slave channel takes two kinds of word, selected by s_tuser: a new
// transfer command (two page pointers and a byte length) or one list entry
// read back from memory. The master channel returns data segments, list
// fetch requests and a done word with status; m_tlast marks the final
// result caused by one input word.
// A classifier accepts one input word per cycle while the queue has room
// and pushes at most one job into a four-entry queue; a sequencer expands
// each job into one to three result words, one per cycle unless stalled.
// A word's first result passes through the queue and the output register.
// List entries stream in at one per cycle while each causes one result; a
// command causes up to three, so a run of commands is limited by the
// sequencer's one result a cycle. When the receiver stalls, the output
// register holds its word, the queue fills and s_tready drops once four
// jobs wait. Reset clears the walk state, the queue and m_tvalid, and sets
// the registers to page shift 12, 512 list entries, buffer disabled.
// Registers are written over the cfg channel, which is always ready.
// ---------------------------------------------------------------------------
module nvme_prp_list_walker_unit
  import nplw_pkg::*;
#(
  parameter int MAX_LIST_ENTRIES = NPLW_MAX_LIST_ENTRIES,
  parameter int QUEUE_DEPTH      = NPLW_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_pointer, second_pointer, transfer_bytes, list_entry
  input  logic [223:0] s_tdata,
  // kind
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // address, amount, in_cmb, status, zero pad
  output logic [87:0]  m_tdata,
  // kind_res
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  localparam int EW = $clog2(MAX_LIST_ENTRIES + 1);
  localparam int CW = (EW > 10) ? EW : 10;

  logic [4:0]  page_shift;
  logic [9:0]  list_entries;
  logic        cmb_enable;
  logic [63:0] cmb_base;
  logic [31:0] cmb_bytes;

  cfg_t          cfg;
  logic [EW-1:0] ents;
  logic [CW-1:0] lep_w;

  job_t push_job, head;
  logic push, pop, q_full, q_empty;

  logic [63:0] o_addr;
  logic [16:0] o_amt;
  logic        o_cmb, o_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift   <= 5'd12;
      list_entries <= 10'd512;
      cmb_enable   <= 1'b0;
      cmb_base     <= 64'd0;
      cmb_bytes    <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAGE_SHIFT:   page_shift   <= cfg_data[4:0];
        REG_LIST_ENTRIES: list_entries <= cfg_data[9:0];
        REG_CMB_ENABLE:   cmb_enable   <= cfg_data[0];
        REG_CMB_BASE:     cmb_base     <= cfg_data;
        REG_CMB_BYTES:    cmb_bytes    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // saturate register values to the supported ranges
  always_comb begin
    if (page_shift < 5'd12) begin
      cfg.sh = 5'd12;
    end else if (page_shift > 5'd16) begin
      cfg.sh = 5'd16;
    end else begin
      cfg.sh = page_shift;
    end
    cfg.cmb_en    = cmb_enable;
    cfg.cmb_base  = cmb_base;
    cfg.cmb_bytes = cmb_bytes;
    lep_w = CW'(list_entries);
    if (lep_w < CW'(2)) begin
      ents = EW'(2);
    end else if (lep_w > CW'(MAX_LIST_ENTRIES)) begin
      ents = EW'(MAX_LIST_ENTRIES);
    end else begin
      ents = EW'(lep_w);
    end
  end

  nplw_front #(
    .MAX_LIST_ENTRIES(MAX_LIST_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ents     (ents),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser[0]),
    .p1       (s_tdata[63:0]),
    .p2       (s_tdata[127:64]),
    .len      (s_tdata[159:128]),
    .ent      (s_tdata[223:160]),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  nplw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  nplw_back #(
    .MAX_LIST_ENTRIES(MAX_LIST_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ents       (ents),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_addr   (o_addr),
    .out_amt    (o_amt),
    .out_cmb    (o_cmb),
    .out_status (o_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'b0, o_status, o_cmb, o_amt, o_addr};

endmodule
